FILE: hdl/wermon_pkg.sv
// ---------------------------------------------------------------------------
// wermon_pkg
// Shared types and constants of the windowed event rate monitor.
// ---------------------------------------------------------------------------
`default_nettype none

package wermon_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam int TIME_W  = 32;
    localparam int KIND_W  = 3;
    localparam int RATE_W  = 17;
    localparam int HELD_W  = 7;

    // Q1.16 value of one
    localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(65536);

    // command codes
    localparam logic [1:0] CMD_RECORD = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_PRUNE  = 2'd2;
    localparam logic [1:0] CMD_IGNORE = 2'd3;

    // action kinds
    localparam logic [KIND_W-1:0] KIND_SHOT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MELEE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DASH  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HEAL  = 3'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [TIME_W-1:0] time_now;
        logic [KIND_W-1:0] action_kind;
    } t_in_item;

    typedef struct packed {
        logic [RATE_W-1:0] aggressive_rate;
        logic [RATE_W-1:0] mobility_rate;
        logic [RATE_W-1:0] caution_rate;
        logic [HELD_W-1:0] entries_held;
    } t_out_item;

    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic [KIND_W-1:0] kind;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REC_RD,
        S_REC_MV,
        S_REC_WR,
        S_SCAN,
        S_DIV_ISSUE,
        S_DIV_WAIT,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: hdl/windowed_event_rate_monitor_top.sv
// ---------------------------------------------------------------------------
// windowed_event_rate_monitor_top
// Table of timestamped events with windowed per-class rate queries.
// ---------------------------------------------------------------------------
// Usage:
//   An item (record, query, prune or ignored command) is taken at a clock
//   edge where start is high and busy is low. Every item gives exactly one
//   result, shown on o_result for one cycle with o_strobe high; the
//   receiver cannot hold it off. busy stays high from the accepting edge
//   until the strobe cycle. The window register is to be written with
//   i_cfg_we / i_cfg_wdata only while idle; the block does not enforce it.
// Work per item (N = events held):
//   record       one table write; when full, last entry moves to front
//   prune        scan of N entries (one table read per cycle) with compaction
//   query        scan of N entries, then three divisions in the shared
//                rate divider (one quotient bit per cycle); a zero window
//                skips scan and division
//   ignored cmd  no table or divider work
// Throughput: one item at a time; the next item can be taken in the strobe
//   cycle. The single table read port and the single divider set these.
// Reset empties the table and clears the window to zero; the table
// contents are left as they are and never read above the fill count.
// ---------------------------------------------------------------------------
`default_nettype none

module windowed_event_rate_monitor_top #(
    parameter int TABLE_DEPTH = wermon_pkg::TABLE_DEPTH_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            start,
    input  wermon_pkg::t_in_item           i_item,
    output logic                           busy,
    output logic                           o_strobe,
    output wermon_pkg::t_out_item          o_result,
    input  wire                            i_cfg_we,
    input  wire [wermon_pkg::TIME_W-1:0]   i_cfg_wdata
);
    import wermon_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] CLS_AGG = 2'd0;
    localparam logic [1:0] CLS_MOB = 2'd1;
    localparam logic [1:0] CLS_CAU = 2'd2;

    t_state            r_state, n_state;
    logic [TIME_W-1:0] r_window;
    logic [1:0]        r_cmd,    n_cmd;
    logic [TIME_W-1:0] r_now,    n_now;
    logic [KIND_W-1:0] r_kind,   n_kind;
    logic [CW-1:0]     r_count,  n_count;
    logic [CW-1:0]     r_idx,    n_idx;
    logic [CW-1:0]     r_keep,   n_keep;
    logic              r_vld,    n_vld;
    logic [CW-1:0]     r_na,     n_na;
    logic [CW-1:0]     r_nm,     n_nm;
    logic [CW-1:0]     r_nc,     n_nc;
    logic [1:0]        r_cls,    n_cls;
    logic [RATE_W-1:0] r_ra,     n_ra;
    logic [RATE_W-1:0] r_rm,     n_rm;
    logic [RATE_W-1:0] r_rc,     n_rc;
    logic              r_strobe, n_strobe;
    t_out_item         r_result, n_result;

    // table port
    logic              w_we, w_re;
    logic [AW-1:0]     w_waddr, w_raddr;
    t_entry            w_wdata, w_rdata;

    // divider port
    logic              w_div_start, w_div_done;
    logic [CW-1:0]     w_div_count;
    logic [RATE_W-1:0] w_div_rate;

    logic              w_accept;
    logic              w_full;
    logic              w_scan_end;
    logic [TIME_W:0]   w_age;
    logic              w_inside;

    assign w_accept   = start && (r_state == S_IDLE);
    assign w_full     = (r_count == CW'(TABLE_DEPTH));
    assign w_scan_end = (r_idx == r_count) && !r_vld;

    // a timestamp later than now (borrow) counts as inside
    assign w_age    = {1'b0, r_now} - {1'b0, w_rdata.stamp};
    assign w_inside = w_age[TIME_W] || (w_age[TIME_W-1:0] <= r_window);

    wermon_table #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    wermon_div #(
        .CNT_W (CW)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_start),
        .i_count  (w_div_count),
        .i_window (r_window),
        .o_done   (w_div_done),
        .o_rate   (w_div_rate)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_item.cmd)
                        CMD_RECORD: n_state = w_full ? S_REC_RD : S_REC_WR;
                        CMD_QUERY:  n_state = (r_window == '0) ? S_DONE : S_SCAN;
                        CMD_PRUNE:  n_state = S_SCAN;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_REC_RD:    n_state = S_REC_MV;
            S_REC_MV:    n_state = S_REC_WR;
            S_REC_WR:    n_state = S_DONE;
            S_SCAN: begin
                if (w_scan_end) begin
                    n_state = (r_cmd == CMD_QUERY) ? S_DIV_ISSUE : S_DONE;
                end
            end
            S_DIV_ISSUE: n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = (r_cls == CLS_CAU) ? S_DONE : S_DIV_ISSUE;
                end
            end
            S_DONE:      n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // datapath and table / divider control
    always_comb begin
        n_cmd    = r_cmd;
        n_now    = r_now;
        n_kind   = r_kind;
        n_count  = r_count;
        n_idx    = r_idx;
        n_keep   = r_keep;
        n_vld    = 1'b0;
        n_na     = r_na;
        n_nm     = r_nm;
        n_nc     = r_nc;
        n_cls    = r_cls;
        n_ra     = r_ra;
        n_rm     = r_rm;
        n_rc     = r_rc;
        n_strobe = 1'b0;
        n_result = r_result;

        w_we        = 1'b0;
        w_waddr     = '0;
        w_wdata     = w_rdata;
        w_re        = 1'b0;
        w_raddr     = r_idx[AW-1:0];
        w_div_start = 1'b0;

        case (r_cls)
            CLS_AGG: w_div_count = r_na;
            CLS_MOB: w_div_count = r_nm;
            default: w_div_count = r_nc;
        endcase

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd  = i_item.cmd;
                    n_now  = i_item.time_now;
                    n_kind = i_item.action_kind;
                    n_idx  = '0;
                    n_keep = '0;
                    n_na   = '0;
                    n_nm   = '0;
                    n_nc   = '0;
                    n_cls  = CLS_AGG;
                    n_ra   = '0;
                    n_rm   = '0;
                    n_rc   = '0;
                end
            end
            S_REC_RD: begin
                w_re    = 1'b1;
                w_raddr = AW'(TABLE_DEPTH - 1);
            end
            S_REC_MV: begin
                // full table: last entry moves to the front
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = w_rdata;
            end
            S_REC_WR: begin
                w_we          = 1'b1;
                w_waddr       = w_full ? AW'(TABLE_DEPTH - 1) : r_count[AW-1:0];
                w_wdata.stamp = r_now;
                w_wdata.kind  = r_kind;
                if (!w_full) begin
                    n_count = CW'(r_count + 1'b1);
                end
            end
            S_SCAN: begin
                if (r_idx != r_count) begin
                    w_re  = 1'b1;
                    n_idx = CW'(r_idx + 1'b1);
                    n_vld = 1'b1;
                end
                if (r_vld && w_inside) begin
                    if (r_cmd == CMD_QUERY) begin
                        case (w_rdata.kind)
                            KIND_SHOT, KIND_MELEE: n_na = CW'(r_na + 1'b1);
                            KIND_DASH:             n_nm = CW'(r_nm + 1'b1);
                            KIND_HEAL:             n_nc = CW'(r_nc + 1'b1);
                            default:               ;
                        endcase
                    end else begin
                        // compaction: write slot never passes the read slot
                        w_we    = 1'b1;
                        w_waddr = r_keep[AW-1:0];
                        w_wdata = w_rdata;
                        n_keep  = CW'(r_keep + 1'b1);
                    end
                end
                if (w_scan_end && (r_cmd == CMD_PRUNE)) begin
                    n_count = r_keep;
                end
            end
            S_DIV_ISSUE: begin
                w_div_start = 1'b1;
            end
            S_DIV_WAIT: begin
                if (w_div_done) begin
                    case (r_cls)
                        CLS_AGG: n_ra = w_div_rate;
                        CLS_MOB: n_rm = w_div_rate;
                        default: n_rc = w_div_rate;
                    endcase
                    n_cls = 2'(r_cls + 1'b1);
                end
            end
            S_DONE: begin
                n_strobe                 = 1'b1;
                n_result.aggressive_rate = r_ra;
                n_result.mobility_rate   = r_rm;
                n_result.caution_rate    = r_rc;
                n_result.entries_held    = HELD_W'(r_count);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_window <= '0;
            r_count  <= '0;
            r_vld    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            r_count  <= n_count;
            r_vld    <= n_vld;
            r_strobe <= n_strobe;
        end
        r_cmd    <= n_cmd;
        r_now    <= n_now;
        r_kind   <= n_kind;
        r_idx    <= n_idx;
        r_keep   <= n_keep;
        r_na     <= n_na;
        r_nm     <= n_nm;
        r_nc     <= n_nc;
        r_cls    <= n_cls;
        r_ra     <= n_ra;
        r_rm     <= n_rm;
        r_rc     <= n_rc;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

`default_nettype wire

FILE: hdl/wermon_table.sv
// ---------------------------------------------------------------------------
// wermon_table
// Event table: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module wermon_table #(
    parameter int DEPTH  = wermon_pkg::TABLE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire                    i_clk,
    input  wire                    i_we,
    input  wire [ADDR_W-1:0]       i_waddr,
    input  wermon_pkg::t_entry     i_wdata,
    input  wire                    i_re,
    input  wire [ADDR_W-1:0]       i_raddr,
    output wermon_pkg::t_entry     o_rdata
);
    import wermon_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/wermon_div.sv
// ---------------------------------------------------------------------------
// wermon_div
// Rate divider: count * 2^24 / window, one quotient bit per cycle,
// saturated to one when count * 256 >= window.
// ---------------------------------------------------------------------------
`default_nettype none

module wermon_div #(
    parameter int CNT_W = 7
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_start,
    input  wire [CNT_W-1:0]                i_count,
    input  wire [wermon_pkg::TIME_W-1:0]   i_window,
    output logic                           o_done,
    output logic [wermon_pkg::RATE_W-1:0]  o_rate
);
    import wermon_pkg::*;

    localparam int STEPS  = 16;
    localparam int STEP_W = $clog2(STEPS);

    logic                r_run,  n_run;
    logic                r_done, n_done;
    logic [TIME_W-1:0]   r_rem,  n_rem;
    logic [STEPS-1:0]    r_q,    n_q;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [RATE_W-1:0]   r_rate, n_rate;

    logic [TIME_W-1:0]   w_scaled;
    logic [TIME_W:0]     w_shift;
    logic [TIME_W:0]     w_diff;
    logic                w_ge;

    always_comb begin
        // quotient below 2^16 once count * 256 < window, so the remainder
        // starts at count * 256 and sixteen zero bits are shifted in
        w_scaled = TIME_W'({i_count, 8'b0});
        w_shift  = {r_rem, 1'b0};
        w_diff   = w_shift - {1'b0, i_window};
        w_ge     = (w_shift >= {1'b0, i_window});

        n_run  = r_run;
        n_done = 1'b0;
        n_rem  = r_rem;
        n_q    = r_q;
        n_step = r_step;
        n_rate = r_rate;

        if (i_start) begin
            if (w_scaled >= i_window) begin
                n_done = 1'b1;
                n_rate = RATE_ONE;
                n_run  = 1'b0;
            end else begin
                n_rem  = w_scaled;
                n_q    = '0;
                n_step = '0;
                n_run  = 1'b1;
            end
        end else if (r_run) begin
            n_rem  = w_ge ? w_diff[TIME_W-1:0] : w_shift[TIME_W-1:0];
            n_q    = {r_q[STEPS-2:0], w_ge};
            n_step = STEP_W'(r_step + 1'b1);
            if (r_step == STEP_W'(STEPS - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
                n_rate = RATE_W'({r_q[STEPS-2:0], w_ge});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_step <= n_step;
        r_rate <= n_rate;
    end

    assign o_done = r_done;
    assign o_rate = r_rate;

endmodule

`default_nettype wire

FILE: tb/windowed_event_rate_monitor_top_tb.sv
// ---------------------------------------------------------------------------
// windowed_event_rate_monitor_top_tb
// Self-checking bench for the event rate monitor. A directed table covers
// the empty table, the zero window, the full table wrap, the window edge
// and the unused command. Random record, query and prune traffic follows
// under several window settings and sender idle rates. Every result
// is checked field by field against a typed row or a local event table model.
// ---------------------------------------------------------------------------
`default_nettype none

module windowed_event_rate_monitor_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import wermon_pkg::*;

    localparam int TABLE_DEPTH    = TABLE_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_SETTLE   = 4;
    localparam int END_SETTLE     = 150;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 215;
    localparam logic [KIND_W-1:0] KIND_OTHER_MAX = 3'd7;

    // one directed row; typed expectations only ever carry zero rates
    typedef struct packed {
        logic              set_wnd;
        logic [TIME_W-1:0] wnd;
        logic [7:0]        reps;
        logic [1:0]        cmd;
        logic [TIME_W-1:0] stamp;
        logic [KIND_W-1:0] kind;
        logic              exp_known;
        logic [HELD_W-1:0] exp_held;
    } t_row;

    localparam int DIRECTED_ROWS = 21;
    localparam t_row DIRECTED [DIRECTED_ROWS] = '{
        // empty table, window zero after reset
        '{1'b0, 32'h0, 8'd1, CMD_QUERY, 32'h0000_0000, KIND_SHOT, 1'b1, 7'd0},
        '{1'b0, 32'h0, 8'd1, CMD_IGNORE, 32'hFFFF_FFFF, KIND_OTHER_MAX, 1'b1, 7'd0},
        '{1'b0, 32'h0, 8'd1, CMD_PRUNE, 32'h0000_0000, KIND_SHOT, 1'b1, 7'd0},
        '{1'b0, 32'h0, 8'd1, CMD_RECORD, 32'h0000_0000, KIND_SHOT, 1'b1, 7'd1},
        '{1'b0, 32'h0, 8'd1, CMD_RECORD, 32'hFFFF_FFFF, KIND_OTHER_MAX, 1'b1, 7'd2},
        '{1'b0, 32'h0, 8'd1, CMD_QUERY, 32'hFFFF_FFFF, KIND_SHOT, 1'b1, 7'd2},
        // widest window
        '{1'b1, 32'hFFFF_FFFF, 8'd1, CMD_RECORD, 32'd100, KIND_MELEE, 1'b1, 7'd3},
        '{1'b0, 32'h0, 8'd1, CMD_RECORD, 32'd200, KIND_DASH, 1'b1, 7'd4},
        '{1'b0, 32'h0, 8'd1, CMD_RECORD, 32'd300, KIND_HEAL, 1'b1, 7'd5},
        '{1'b0, 32'h0, 8'd1, CMD_QUERY, 32'd1000, KIND_SHOT, 1'b0, 7'd0},
        '{1'b0, 32'h0, 8'd1, CMD_QUERY, 32'd0, KIND_SHOT, 1'b0, 7'd0},
        // narrowest nonzero window, future stamps stay inside
        '{1'b1, 32'd1, 8'd1, CMD_QUERY, 32'd300, KIND_SHOT, 1'b0, 7'd0},
        '{1'b0, 32'h0, 8'd1, CMD_PRUNE, 32'd300, KIND_SHOT, 1'b0, 7'd0},
        // overfill the table so the wrap of entry 0 shows in the counts
        '{1'b1, 32'h0100_0000, 8'd70, CMD_RECORD, 32'h500, KIND_DASH, 1'b0, 7'd0},
        '{1'b0, 32'h0, 8'd1, CMD_QUERY, 32'h500, KIND_SHOT, 1'b0, 7'd0},
        '{1'b0, 32'h0, 8'd1, CMD_PRUNE, 32'hFFFF_FFFF, KIND_SHOT, 1'b0, 7'd0},
        // age exactly at the window, then one past it
        '{1'b0, 32'h0, 8'd1, CMD_RECORD, 32'h0, KIND_SHOT, 1'b0, 7'd0},
        '{1'b0, 32'h0, 8'd1, CMD_QUERY, 32'h0100_0000, KIND_SHOT, 1'b0, 7'd0},
        '{1'b0, 32'h0, 8'd1, CMD_QUERY, 32'h0100_0001, KIND_SHOT, 1'b0, 7'd0},
        '{1'b0, 32'h0, 8'd1, CMD_IGNORE, 32'h0, KIND_SHOT, 1'b0, 7'd0},
        '{1'b0, 32'h0, 8'd1, CMD_PRUNE, 32'h0100_0001, KIND_SHOT, 1'b0, 7'd0}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    t_in_item          i_item = '0;
    logic              busy;
    logic              o_strobe;
    t_out_item         o_result;
    logic              i_cfg_we = 1'b0;
    logic [TIME_W-1:0] i_cfg_wdata = '0;

    windowed_event_rate_monitor_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_item     (i_item),
        .busy       (busy),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // local copy of the event table and window
    logic [TIME_W-1:0] wnd_len = '0;
    logic [TIME_W-1:0] ev_stamp [TABLE_DEPTH];
    logic [KIND_W-1:0] ev_kind  [TABLE_DEPTH];
    int unsigned       ev_fill = 0;

    t_out_item         rate_expect_q [$];
    int unsigned       mismatches = 0;
    int unsigned       quiet_cycles = 0;
    int unsigned       sender_idle_pct = 0;
    logic [TIME_W-1:0] clock_now = '0;

    function automatic logic in_window(input logic [TIME_W-1:0] now,
                                       input logic [TIME_W-1:0] stamp);
        if (stamp > now)
            return 1'b1;
        return (now - stamp) <= wnd_len;
    endfunction

    function automatic logic [RATE_W-1:0] class_rate(input int unsigned n);
        logic [63:0] w;
        logic [63:0] numer;
        w = 64'(wnd_len);
        if (w == 0)
            return '0;
        if (64'(n) * 256 >= w)
            return RATE_ONE;
        numer = 64'(n) << 24;
        return RATE_W'(numer / w);
    endfunction

    function automatic t_out_item predict_event_rates(input t_in_item it);
        t_out_item   res;
        int unsigned n_agg;
        int unsigned n_mob;
        int unsigned n_cau;
        int unsigned kept;
        res = '0;
        n_agg = 0;
        n_mob = 0;
        n_cau = 0;
        kept = 0;
        case (it.cmd)
            CMD_RECORD: begin
                // full table: last entry moves to slot 0, new event takes the last
                if (ev_fill >= TABLE_DEPTH) begin
                    ev_stamp[0] = ev_stamp[TABLE_DEPTH-1];
                    ev_kind[0]  = ev_kind[TABLE_DEPTH-1];
                    ev_fill     = TABLE_DEPTH - 1;
                end
                ev_stamp[ev_fill] = it.time_now;
                ev_kind[ev_fill]  = it.action_kind;
                ev_fill++;
            end
            CMD_QUERY: begin
                for (int i = 0; i < ev_fill; i++) begin
                    if (in_window(it.time_now, ev_stamp[i])) begin
                        case (ev_kind[i])
                            KIND_SHOT, KIND_MELEE: n_agg++;
                            KIND_DASH:             n_mob++;
                            KIND_HEAL:             n_cau++;
                            default: ;
                        endcase
                    end
                end
                res.aggressive_rate = class_rate(n_agg);
                res.mobility_rate   = class_rate(n_mob);
                res.caution_rate    = class_rate(n_cau);
            end
            CMD_PRUNE: begin
                for (int i = 0; i < ev_fill; i++) begin
                    if (in_window(it.time_now, ev_stamp[i])) begin
                        ev_stamp[kept] = ev_stamp[i];
                        ev_kind[kept]  = ev_kind[i];
                        kept++;
                    end
                end
                ev_fill = kept;
            end
            default: ;
        endcase
        res.entries_held = HELD_W'(ev_fill);
        return res;
    endfunction

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endtask

    // start stays high across back-to-back items, dropped only for idle cycles and while draining
    task automatic send_item(input t_in_item it, input logic exp_known,
                             input logic [HELD_W-1:0] exp_held);
        t_out_item want;
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        want = predict_event_rates(it);
        if (exp_known) begin
            want = '0;
            want.entries_held = exp_held;
        end
        rate_expect_q.push_back(want);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (rate_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [TIME_W-1:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        wnd_len = value;
    endtask

    task automatic run_random(input int unsigned n_items);
        t_in_item    it;
        int unsigned sent;
        int unsigned pick;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            clock_now += $urandom_range(0, 'h300);
            // now and then a long jump so old events age out
            if ($urandom_range(31) == 0)
                clock_now += $urandom_range(0, 'h10000);
            it.cmd = (pick < 50) ? CMD_RECORD :
                     (pick < 80) ? CMD_QUERY  :
                     (pick < 97) ? CMD_PRUNE  : CMD_IGNORE;
            it.time_now = clock_now;
            if ($urandom_range(15) == 0)
                it.time_now = $urandom;
            else if ($urandom_range(7) == 0)
                it.time_now = clock_now - $urandom_range(0, 'h800);
            it.action_kind = ($urandom_range(99) < 70) ? KIND_W'($urandom_range(3))
                                                       : KIND_W'($urandom_range(7));
            send_item(it, 1'b0, '0);
            if (it.cmd != CMD_IGNORE) begin
                sent++;
                // hold off once per phase until the table work is all back
                if (sent == n_items / 2)
                    wait_drained();
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (rate_expect_q.size() == 0) begin
                report($sformatf("result with no item pending: %h", o_result));
            end else begin
                want = rate_expect_q.pop_front();
                if (o_result.aggressive_rate !== want.aggressive_rate)
                    report($sformatf("aggressive_rate expected %0d got %0d",
                                     want.aggressive_rate, o_result.aggressive_rate));
                if (o_result.mobility_rate !== want.mobility_rate)
                    report($sformatf("mobility_rate expected %0d got %0d",
                                     want.mobility_rate, o_result.mobility_rate));
                if (o_result.caution_rate !== want.caution_rate)
                    report($sformatf("caution_rate expected %0d got %0d",
                                     want.caution_rate, o_result.caution_rate));
                if (o_result.entries_held !== want.entries_held)
                    report($sformatf("entries_held expected %0d got %0d",
                                     want.entries_held, o_result.entries_held));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_strobe === 1'b1) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("windowed_event_rate_monitor_top test failed");
                $finish;
            end
        end
    end

    initial begin
        t_row        row;
        t_in_item    it;
        logic [TIME_W-1:0] wnd;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            row = DIRECTED[r];
            if (row.set_wnd)
                write_window(row.wnd);
            it.cmd         = row.cmd;
            it.time_now    = row.stamp;
            it.action_kind = row.kind;
            repeat (row.reps) send_item(it, row.exp_known, row.exp_held);
        end

        clock_now = $urandom;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: wnd = $urandom_range('h100, 'h1000);
                1: wnd = $urandom_range('h1000, 'h40000);
                2: wnd = $urandom;
                3: wnd = $urandom_range('h80, 'h800);
                4: wnd = 32'hFFFF_FFFF;
                default: wnd = $urandom_range(1, 'h200);
            endcase
            write_window(wnd);
            // no idling, mostly idle, then lightly idle
            case (p / 2)
                0: sender_idle_pct = 0;
                1: sender_idle_pct = 78;
                default: sender_idle_pct = 11;
            endcase
            run_random(PHASE_ITEMS);
        end

        wait_drained();
        repeat (END_SETTLE) @(posedge i_clk);
        if (mismatches == 0 && rate_expect_q.size() == 0)
            $display("windowed_event_rate_monitor_top test passed");
        else
            $display("windowed_event_rate_monitor_top test failed");
        $finish;
    end

endmodule

`default_nettype wire
